>>> rtl/core/utf8_stream_validator_assert.svh
// ----------------------------------------------------------------------------
// utf8_stream_validator assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// same-cycle implication
`define U8V_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U8V_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types, constants and the scalar check for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

	localparam int CP_W       = 21;
	localparam int BYTE_W     = 8;
	localparam int TDATA_IN_W = 8;
	localparam int TDATA_OUT_W = 24;
	localparam int TUSER_OUT_W = 3;

	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] NONCHAR_LO = 21'h00FDD0;
	localparam logic [CP_W-1:0] NONCHAR_HI = 21'h00FDEF;
	localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	localparam logic [1:0] CONT_TAG = 2'b10;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} in_t;

	typedef struct packed {
		logic            char_complete;
		logic [CP_W-1:0] code_point;
		logic            error_seen;
		logic            string_end;
		logic            string_valid;
	} result_t;

	typedef struct packed {
		logic [1:0] bytes_left;
		logic [2:0] seq_length;
		logic       bad_flag;
	} dec_state_t;

	// overlong, range, surrogate and noncharacter checks
	function automatic logic scalar_ok(input logic [CP_W-1:0] cp, input logic [2:0] len);
		logic ok;
		ok = 1'b1;
		if (len == LEN_2 && cp < MIN_LEN2)
			ok = 1'b0;
		if (len == LEN_3 && cp < MIN_LEN3)
			ok = 1'b0;
		if (len == LEN_4 && cp < MIN_LEN4)
			ok = 1'b0;
		if (cp > CP_MAX)
			ok = 1'b0;
		if (cp >= SURR_LO && cp <= SURR_HI)
			ok = 1'b0;
		if (cp >= NONCHAR_LO && cp <= NONCHAR_HI)
			ok = 1'b0;
		if (cp[15:1] == 15'h7FFF)
			ok = 1'b0;
		return ok;
	endfunction

endpackage

>>> rtl/core/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 checker, one byte per item, one result item per byte.
// ----------------------------------------------------------------------------
// Takes one byte per clock while neither side stalls and returns one result
// per byte through an input register, the decode logic and the sequence state
// registers, then an output register. Throughput is one byte per clock, set by
// the sequence state (bytes left, length, partial codepoint, sticky error)
// moving on each accepted byte; either side may stall without loss. Each result
// reports a completed codepoint, the sticky error, and on the byte marked
// tlast the final verdict, after which the state clears for the next string.
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_assert.svh"

module utf8_stream_validator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [utf8v_pkg::TDATA_IN_W-1:0]    s_tdata,   // [7:0] data_byte
	input  logic                                s_tlast,   // last_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [utf8v_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [20:0] code_point, [23:21] zero
	output logic [utf8v_pkg::TUSER_OUT_W-1:0]   m_tuser,   // [0] char_complete, [1] error_seen,
	                                                       // [2] string_valid
	output logic                                m_tlast    // string_end
);

	logic                   advance;
	logic                   valid_s1;
	logic                   fire;
	utf8v_pkg::in_t         item_s1;
	utf8v_pkg::result_t     result;
	utf8v_pkg::dec_state_t  dec_state;

	assign fire = valid_s1 && advance;

	utf8v_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	utf8v_decoder u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result),
		.state  (dec_state)
	);

	utf8v_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.result   (result),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`U8V_ASSERT_SAME(a_cp_only_on_char, m_tvalid && !m_tuser[0], m_tdata == '0, "code point without char")
	`U8V_ASSERT_SAME(a_valid_on_end, m_tvalid && m_tuser[2], m_tlast && !m_tuser[1], "bad verdict")
	`U8V_ASSERT_SAME(a_cp_range, m_tvalid, m_tdata <= {3'd0, utf8v_pkg::CP_MAX}, "code point range")
	`U8V_ASSERT_NEXT(a_clear_after_end, fire && item_s1.last_byte, dec_state == '0, "state not cleared")

endmodule

>>> rtl/core/utf8v_in_stage.sv
// ----------------------------------------------------------------------------
// utf8v_in_stage
// Input register: holds one accepted byte until the decoder takes it.
// ----------------------------------------------------------------------------
module utf8v_in_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [utf8v_pkg::TDATA_IN_W-1:0]    s_tdata,
	input  logic                                s_tlast,
	input  logic                                advance,
	output logic                                valid_s1,
	output utf8v_pkg::in_t                      item_s1
);

	logic take;

	// stage frees up when it is empty or its item moves on this cycle
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte <= s_tdata[utf8v_pkg::BYTE_W-1:0];
			item_s1.last_byte <= s_tlast;
		end
	end

endmodule

>>> rtl/core/utf8v_decoder.sv
// ----------------------------------------------------------------------------
// utf8v_decoder
// Sequence state and per-byte decode; state moves only when an item fires.
// ----------------------------------------------------------------------------
module utf8v_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  utf8v_pkg::in_t         item,
	output utf8v_pkg::result_t     result,
	output utf8v_pkg::dec_state_t  state
);

	logic [1:0]                  bytes_left_q;
	logic [2:0]                  seq_length_q;
	logic [utf8v_pkg::CP_W-1:0]  partial_q;
	logic                        bad_q;

	logic [1:0]                  bl_d;
	logic [2:0]                  len_d;
	logic [utf8v_pkg::CP_W-1:0]  part_d;
	logic                        bad_d;
	logic                        done;
	logic [utf8v_pkg::CP_W-1:0]  cp;
	logic [utf8v_pkg::CP_W-1:0]  shifted;
	logic [7:0]                  b;

	assign b       = item.data_byte;
	assign shifted = {partial_q[utf8v_pkg::CP_W-7:0], b[5:0]};

	always_comb begin
		bl_d   = bytes_left_q;
		len_d  = seq_length_q;
		part_d = partial_q;
		bad_d  = bad_q;
		done   = 1'b0;
		cp     = '0;
		if (bytes_left_q == 2'd0) begin
			if (!b[7]) begin
				done = 1'b1;
				cp   = {13'd0, b};
			end else if (b[7:5] == 3'b110) begin
				len_d  = utf8v_pkg::LEN_2;
				bl_d   = 2'd1;
				part_d = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				len_d  = utf8v_pkg::LEN_3;
				bl_d   = 2'd2;
				part_d = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				len_d  = utf8v_pkg::LEN_4;
				bl_d   = 2'd3;
				part_d = {18'd0, b[2:0]};
			end else begin
				// stray continuation or F8..FF lead
				bad_d = 1'b1;
			end
		end else if (b[7:6] != utf8v_pkg::CONT_TAG) begin
			bad_d  = 1'b1;
			bl_d   = 2'd0;
			len_d  = utf8v_pkg::LEN_NONE;
			part_d = '0;
		end else begin
			part_d = shifted;
			bl_d   = bytes_left_q - 2'd1;
			if (bytes_left_q == 2'd1) begin
				if (utf8v_pkg::scalar_ok(shifted, seq_length_q)) begin
					done = 1'b1;
					cp   = shifted;
				end else begin
					bad_d = 1'b1;
				end
				len_d  = utf8v_pkg::LEN_NONE;
				part_d = '0;
			end
		end
		// unfinished sequence at end of string
		if (item.last_byte && bl_d != 2'd0)
			bad_d = 1'b1;
	end

	always_comb begin
		result.char_complete = done;
		result.code_point    = cp;
		result.error_seen    = bad_d;
		result.string_end    = item.last_byte;
		result.string_valid  = item.last_byte && !bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
			seq_length_q <= utf8v_pkg::LEN_NONE;
			partial_q    <= '0;
			bad_q        <= 1'b0;
		end else if (fire) begin
			if (item.last_byte) begin
				bytes_left_q <= 2'd0;
				seq_length_q <= utf8v_pkg::LEN_NONE;
				partial_q    <= '0;
				bad_q        <= 1'b0;
			end else begin
				bytes_left_q <= bl_d;
				seq_length_q <= len_d;
				partial_q    <= part_d;
				bad_q        <= bad_d;
			end
		end
	end

	assign state.bytes_left = bytes_left_q;
	assign state.seq_length = seq_length_q;
	assign state.bad_flag   = bad_q;

endmodule

>>> rtl/core/utf8v_out_stage.sv
// ----------------------------------------------------------------------------
// utf8v_out_stage
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
module utf8v_out_stage (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  utf8v_pkg::result_t                   result,
	output logic                                 advance,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [utf8v_pkg::TDATA_OUT_W-1:0]    m_tdata,
	output logic [utf8v_pkg::TUSER_OUT_W-1:0]    m_tuser,
	output logic                                 m_tlast
);

	// register can take a new item when empty or being drained
	assign advance = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && advance) begin
			m_tdata <= {{(utf8v_pkg::TDATA_OUT_W - utf8v_pkg::CP_W){1'b0}}, result.code_point};
			m_tuser <= {result.string_valid, result.error_seen, result.char_complete};
			m_tlast <= result.string_end;
		end
	end

endmodule

>>> bench/tb_utf8_stream_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_validator
// Drives byte strings through the validator and checks every result item
// against a decoder kept in the bench. Strings are mostly well-formed text with
// random characters, mixed with overlong, out-of-range, surrogate,
// noncharacter, truncated and badly tagged sequences and raw noise. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_utf8_stream_validator;

	localparam int unsigned ITEM_TARGET = 1450;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 8;

	// decoder state plus the queue of result items still owed by the block
	class utf8_decode_ledger;
		logic [1:0]                 cont_left;
		logic [2:0]                 run_len;
		logic [utf8v_pkg::CP_W-1:0] gathered;
		logic                       sticky_bad;
		utf8v_pkg::result_t         owed[$];
		int unsigned                failures;
		int unsigned                result_idx;

		function new();
			clear_string();
			failures = 0;
			result_idx = 0;
		endfunction

		function void clear_string();
			cont_left = 2'd0;
			run_len = utf8v_pkg::LEN_NONE;
			gathered = '0;
			sticky_bad = 1'b0;
		endfunction

		function bit point_allowed(logic [utf8v_pkg::CP_W-1:0] cp, logic [2:0] len);
			logic [utf8v_pkg::CP_W-1:0] floor_val;
			case (len)
				utf8v_pkg::LEN_2: floor_val = utf8v_pkg::MIN_LEN2;
				utf8v_pkg::LEN_3: floor_val = utf8v_pkg::MIN_LEN3;
				utf8v_pkg::LEN_4: floor_val = utf8v_pkg::MIN_LEN4;
				default: floor_val = '0;
			endcase
			if (cp < floor_val || cp > utf8v_pkg::CP_MAX)
				return 1'b0;
			if (cp >= utf8v_pkg::SURR_LO && cp <= utf8v_pkg::SURR_HI)
				return 1'b0;
			if (cp >= utf8v_pkg::NONCHAR_LO && cp <= utf8v_pkg::NONCHAR_HI)
				return 1'b0;
			// xxFFFE / xxFFFF in every plane
			if (cp[15:0] >= 16'hFFFE)
				return 1'b0;
			return 1'b1;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			utf8v_pkg::result_t r;
			r = '0;
			if (cont_left == 2'd0) begin
				if (!b[7]) begin
					r.char_complete = 1'b1;
					r.code_point = {13'd0, b};
				end else if (b[7:5] == 3'b110) begin
					run_len = utf8v_pkg::LEN_2;
					cont_left = 2'd1;
					gathered = {16'd0, b[4:0]};
				end else if (b[7:4] == 4'b1110) begin
					run_len = utf8v_pkg::LEN_3;
					cont_left = 2'd2;
					gathered = {17'd0, b[3:0]};
				end else if (b[7:3] == 5'b11110) begin
					run_len = utf8v_pkg::LEN_4;
					cont_left = 2'd3;
					gathered = {18'd0, b[2:0]};
				end else begin
					// stray continuation or F8..FF: flagged and dropped
					sticky_bad = 1'b1;
				end
			end else if (b[7:6] != utf8v_pkg::CONT_TAG) begin
				// byte is swallowed, not retried as a lead
				sticky_bad = 1'b1;
				cont_left = 2'd0;
				run_len = utf8v_pkg::LEN_NONE;
				gathered = '0;
			end else begin
				gathered = {gathered[utf8v_pkg::CP_W-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					if (point_allowed(gathered, run_len)) begin
						r.char_complete = 1'b1;
						r.code_point = gathered;
					end else begin
						sticky_bad = 1'b1;
					end
					run_len = utf8v_pkg::LEN_NONE;
					gathered = '0;
				end
			end
			if (last && cont_left != 2'd0)
				sticky_bad = 1'b1;
			r.error_seen = sticky_bad;
			r.string_end = last;
			r.string_valid = last && !sticky_bad;
			owed.push_back(r);
			if (last)
				clear_string();
		endfunction

		function void check_result(utf8v_pkg::result_t got, logic [2:0] pad);
			utf8v_pkg::result_t want;
			if (owed.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result item: done=%0b cp=%06h err=%0b end=%0b ok=%0b",
						$time, got.char_complete, got.code_point, got.error_seen,
						got.string_end, got.string_valid);
				return;
			end
			want = owed.pop_front();
			if (got !== want || pad !== 3'd0) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: result %0d: expected done=%0b cp=%06h err=%0b end=%0b ok=%0b",
						$time, result_idx, want.char_complete, want.code_point,
						want.error_seen, want.string_end, want.string_valid);
					$display("    got done=%0b cp=%06h err=%0b end=%0b ok=%0b pad=%0b",
						got.char_complete, got.code_point, got.error_seen,
						got.string_end, got.string_valid, pad);
				end
			end
			result_idx++;
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [utf8v_pkg::TDATA_IN_W-1:0]  s_tdata;
	logic                              s_tlast;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [utf8v_pkg::TDATA_OUT_W-1:0] m_tdata;
	logic [utf8v_pkg::TUSER_OUT_W-1:0] m_tuser;
	logic                              m_tlast;

	utf8_decode_ledger  ledger;
	utf8v_pkg::result_t seen_result;
	logic [7:0]         string_bytes[$];
	int unsigned        sent_total;
	int unsigned        cycle_count;
	bit                 tx_steady;
	bit                 rx_steady;

	utf8_stream_validator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("utf8_stream_validator: mismatch");
		$finish;
	end

	// input notes come first so the decoder order matches acceptance order
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				ledger.note_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				seen_result.char_complete = m_tuser[0];
				seen_result.code_point = m_tdata[utf8v_pkg::CP_W-1:0];
				seen_result.error_seen = m_tuser[1];
				seen_result.string_end = m_tlast;
				seen_result.string_valid = m_tuser[2];
				ledger.check_result(seen_result,
					m_tdata[utf8v_pkg::TDATA_OUT_W-1:utf8v_pkg::CP_W]);
			end
		end
	end

	function automatic int unsigned draw_wait(bit steady);
		return steady ? 0 : $urandom_range(0, 17);
	endfunction

	// receiver: random stall before each result item
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_steady = !rx_steady;
			stall = draw_wait(rx_steady);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	function automatic void push_encoded(logic [utf8v_pkg::CP_W-1:0] cp, int unsigned len);
		case (len)
			1: string_bytes.push_back({1'b0, cp[6:0]});
			2: begin
				string_bytes.push_back({3'b110, cp[10:6]});
				string_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				string_bytes.push_back({4'b1110, cp[15:12]});
				string_bytes.push_back({2'b10, cp[11:6]});
				string_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				string_bytes.push_back({5'b11110, cp[20:18]});
				string_bytes.push_back({2'b10, cp[17:12]});
				string_bytes.push_back({2'b10, cp[11:6]});
				string_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	task automatic add_random_char();
		int unsigned                kind;
		int unsigned                len;
		int unsigned                cut;
		int unsigned                pos;
		int unsigned                pick;
		logic [utf8v_pkg::CP_W-1:0] cp;
		logic [1:0]                 tag;
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			push_encoded(21'($urandom_range(0, 'h7F)), 1);
		end else if (kind < 40) begin
			cp = 21'($urandom_range('h80, 'h7FF));
			if ($urandom_range(0, 7) == 0)
				cp = $urandom_range(0, 1) ? 21'h80 : 21'h7FF;
			push_encoded(cp, 2);
		end else if (kind < 58) begin
			cp = 21'($urandom_range('h800, 'hFFFF));
			if ($urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, 11);
				case (pick)
					0: cp = 21'h0800;
					1: cp = 21'hD7FF;
					2: cp = 21'hD800;
					3: cp = 21'hDFFF;
					4: cp = 21'hE000;
					5: cp = 21'hFDCF;
					6: cp = 21'hFDD0;
					7: cp = 21'hFDEF;
					8: cp = 21'hFDF0;
					9: cp = 21'hFFFD;
					10: cp = 21'hFFFE;
					default: cp = 21'hFFFF;
				endcase
			end
			push_encoded(cp, 3);
		end else if (kind < 72) begin
			cp = 21'($urandom_range('h10000, 'h10FFFF));
			if ($urandom_range(0, 4) == 0) begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: cp = 21'h10000;
					1: cp = 21'h10FFFD;
					2: cp = 21'h10FFFF;
					default: cp = {5'($urandom_range(1, 16)), 15'h7FFF, 1'($urandom_range(0, 1))};
				endcase
			end
			push_encoded(cp, 4);
		end else if (kind < 78) begin
			// overlong: value fits a shorter form
			len = $urandom_range(2, 4);
			case (len)
				2: cp = 21'($urandom_range(0, 'h7F));
				3: cp = 21'($urandom_range(0, 'h7FF));
				default: cp = 21'($urandom_range(0, 'hFFFF));
			endcase
			push_encoded(cp, len);
		end else if (kind < 82) begin
			push_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
		end else if (kind < 88) begin
			string_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 94) begin
			// sequence cut short
			len = $urandom_range(2, 4);
			cut = $urandom_range(1, len - 1);
			push_encoded(21'($urandom_range(0, 'h1FFFFF)), len);
			repeat (cut) void'(string_bytes.pop_back());
		end else begin
			// one continuation byte with the wrong tag
			len = $urandom_range(2, 4);
			push_encoded(21'($urandom_range(0, 'h1FFFFF)), len);
			pos = string_bytes.size() - $urandom_range(1, len - 1);
			pick = $urandom_range(0, 2);
			tag = (pick == 2) ? 2'b11 : 2'(pick);
			string_bytes[pos] = {tag, 6'($urandom_range(0, 63))};
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = draw_wait(tx_steady);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent_total++;
	endtask

	task automatic drive_string();
		for (int i = 0; i < string_bytes.size(); i++)
			send_byte(string_bytes[i], i == string_bytes.size() - 1);
	endtask

	task automatic wait_for_drain();
		s_tvalid = 1'b0;
		while (ledger.pending() != 0) @(negedge clk);
	endtask

	initial begin
		int unsigned nchars;
		ledger = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		sent_total = 0;
		cycle_count = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// valid text with one-, two- and three-byte characters
		string_bytes = '{8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBD, 8'h7F};
		drive_string();
		string_bytes = '{8'hC0, 8'h80};               // overlong
		drive_string();
		string_bytes = '{8'hED, 8'hA0, 8'h80};        // surrogate
		drive_string();
		string_bytes = '{8'hEF, 8'hB7, 8'h90};        // noncharacter block
		drive_string();
		string_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; // above the last plane
		drive_string();
		// stray continuation, F8..FF lead, decoding goes on after the error
		string_bytes = '{8'h80, 8'hFF, 8'h41};
		drive_string();
		// missing tag, then end inside a sequence
		string_bytes = '{8'hC3, 8'h41, 8'hE2};
		drive_string();
		string_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80};
		drive_string();
		wait_for_drain();

		while (sent_total < ITEM_TARGET) begin
			string_bytes.delete();
			nchars = $urandom_range(1, 10);
			repeat (nchars) add_random_char();
			tx_steady = ($urandom_range(0, 3) == 0);
			drive_string();
			if ($urandom_range(0, 39) == 0)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (ledger.failures == 0 && ledger.pending() == 0)
			$display("utf8_stream_validator: match");
		else
			$display("utf8_stream_validator: mismatch");
		$finish;
	end

endmodule
